FILE: hdl/xrfw_pkg.sv
// Shared constants, codes and types of the XMODEM receiver flash writer.
package xrfw_pkg;

   localparam int DATA_BYTES   = 128;
   localparam int PAGE_BYTES   = 256;
   localparam int PACKET_BYTES = DATA_BYTES + 4;

   localparam int ADDR_W      = 24;
   localparam int PAGE_FILL_W = $clog2(PAGE_BYTES + 1);
   localparam int PKT_REM_W   = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Commands on the request channel.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   // Actions on the response channel.
   localparam logic [2:0] ACT_SEND    = 3'd0;
   localparam logic [2:0] ACT_DATA    = 3'd1;
   localparam logic [2:0] ACT_ERASE   = 3'd2;
   localparam logic [2:0] ACT_PROGRAM = 3'd3;
   localparam logic [2:0] ACT_DONE    = 3'd4;
   localparam logic [2:0] ACT_TIMEOUT = 3'd5;
   localparam logic [2:0] ACT_CANCEL  = 3'd6;

   // Protocol characters.
   localparam logic [7:0] CH_SOH   = 8'h01;
   localparam logic [7:0] CH_EOT   = 8'h04;
   localparam logic [7:0] CH_ACK   = 8'h06;
   localparam logic [7:0] CH_ETB   = 8'h17;
   localparam logic [7:0] CH_CAN   = 8'h18;
   localparam logic [7:0] CH_START = 8'h43;

   // Transfer phases.
   localparam logic [1:0] PH_WAIT    = 2'd0;
   localparam logic [1:0] PH_PACKET  = 2'd1;
   localparam logic [1:0] PH_BETWEEN = 2'd2;

   // Job kinds handed from the front end to the back end.
   localparam logic [2:0] JOB_SEND_C         = 3'd0;
   localparam logic [2:0] JOB_TIMEOUT        = 3'd1;
   localparam logic [2:0] JOB_DATA           = 3'd2;
   localparam logic [2:0] JOB_ACK            = 3'd3;
   localparam logic [2:0] JOB_ACK_PROG       = 3'd4;
   localparam logic [2:0] JOB_ACK_ERASE_PROG = 3'd5;
   localparam logic [2:0] JOB_ACK_DONE       = 3'd6;
   localparam logic [2:0] JOB_CANCEL         = 3'd7;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
   localparam logic [1:0] REG_BASE_ADDRESS  = 2'd2;

   typedef struct packed {
      logic [7:0]        retry_limit;
      logic [15:0]       timeout_ticks;
      logic [ADDR_W-1:0] base_address;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [7:0]        data_byte;
      logic [7:0]        page_offset;
      logic [ADDR_W-1:0] flash_address;
   } job_type;

endpackage

FILE: hdl/xmodem_receiver_flash_writer.sv
// Top level of the XMODEM receiver that turns received bytes into flash page writes.
//
// The block takes one request beat per cycle as long as its four-entry job queue has room.
// The front end updates the protocol state in the cycle a beat is accepted and queues at most
// one job; the back end turns each job into one to three response beats, one per cycle while
// the response channel is ready, through a registered output stage. A request has three
// results at the end of a packet that fills a page on a 64 KiB boundary, or on a cancel, and a
// request with no result queues no job. The response channel may stall freely; requests are
// held off only when the queue is full. Each response beat of a request carries tlast on its
// final beat. Configuration must be written while idle.
module xmodem_receiver_flash_writer (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] command
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] data_byte, [15:8] page_offset, [39:16] flash_address
   output logic [2:0]  rsp_tuser,   // [2:0] action
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import xrfw_pkg::*;

   cfg_type cfg;
   job_type push_job;
   job_type head_job;
   logic    accept;
   logic    job_push;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   xrfw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   xrfw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .command  (req_tuser),
      .rx_byte  (req_tdata),
      .job_push (job_push),
      .job      (push_job)
   );

   xrfw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   xrfw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (head_job),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: hdl/xrfw_csr.sv
// Configuration register file on an APB-style port.
module xrfw_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output xrfw_pkg::cfg_type  cfg
);
   import xrfw_pkg::*;

   logic [7:0]        retry_limit_ff,   retry_limit_in;
   logic [15:0]       timeout_ticks_ff, timeout_ticks_in;
   logic [ADDR_W-1:0] base_address_ff,  base_address_in;
   logic              wr_en;
   logic [1:0]        reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      retry_limit_in   = retry_limit_ff;
      timeout_ticks_in = timeout_ticks_ff;
      base_address_in  = base_address_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_RETRY_LIMIT:   retry_limit_in   = csr_pwdata[7:0];
            REG_TIMEOUT_TICKS: timeout_ticks_in = csr_pwdata[15:0];
            REG_BASE_ADDRESS:  base_address_in  = csr_pwdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_RETRY_LIMIT:   csr_prdata = {24'd0, retry_limit_ff};
         REG_TIMEOUT_TICKS: csr_prdata = {16'd0, timeout_ticks_ff};
         REG_BASE_ADDRESS:  csr_prdata = {{(32-ADDR_W){1'b0}}, base_address_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff   <= 8'd100;
         timeout_ticks_ff <= 16'd100;
         base_address_ff  <= '0;
      end else begin
         retry_limit_ff   <= retry_limit_in;
         timeout_ticks_ff <= timeout_ticks_in;
         base_address_ff  <= base_address_in;
      end
   end

   assign cfg.retry_limit   = retry_limit_ff;
   assign cfg.timeout_ticks = timeout_ticks_ff;
   assign cfg.base_address  = base_address_ff;

endmodule

FILE: hdl/xrfw_front.sv
// Front end: protocol state machine that turns each accepted beat into at most one job.
module xrfw_front (
   input  logic               clock,
   input  logic               reset,
   input  xrfw_pkg::cfg_type  cfg,
   input  logic               accept,
   input  logic [1:0]         command,
   input  logic [7:0]         rx_byte,
   output logic               job_push,
   output xrfw_pkg::job_type  job
);
   import xrfw_pkg::*;

   logic                   active_ff,   active_in;
   logic [1:0]             phase_ff,    phase_in;
   logic [PKT_REM_W-1:0]   pkt_rem_ff,  pkt_rem_in;
   logic [PAGE_FILL_W-1:0] fill_ff,     fill_in;
   logic [ADDR_W-1:0]      addr_ff,     addr_in;
   logic [15:0]            tick_ff,     tick_in;
   logic [7:0]             retries_ff,  retries_in;

   logic                   has_job;
   logic [7:0]             retries_dec;
   logic [PKT_REM_W-1:0]   rem_dec;
   logic                   is_data;

   always_comb begin
      active_in  = active_ff;
      phase_in   = phase_ff;
      pkt_rem_in = pkt_rem_ff;
      fill_in    = fill_ff;
      addr_in    = addr_ff;
      tick_in    = tick_ff;
      retries_in = retries_ff;
      has_job    = 1'b0;
      job        = '0;

      retries_dec = (retries_ff != 8'd0) ? retries_ff - 8'd1 : 8'd0;
      rem_dec     = (pkt_rem_ff != '0) ? pkt_rem_ff - PKT_REM_W'(1) : '0;
      // Data bytes sit between the block number pair and the CRC pair.
      is_data = (pkt_rem_ff <= PKT_REM_W'(PACKET_BYTES - 2))
             && (pkt_rem_ff >  PKT_REM_W'(PACKET_BYTES - 2 - DATA_BYTES))
             && (fill_ff < PAGE_FILL_W'(PAGE_BYTES));

      if (command == CMD_START) begin
         active_in  = 1'b1;
         phase_in   = PH_WAIT;
         pkt_rem_in = '0;
         retries_in = cfg.retry_limit;
         tick_in    = cfg.timeout_ticks;
         addr_in    = cfg.base_address;
         has_job    = 1'b1;
         job.kind   = JOB_SEND_C;
      end else if (command == CMD_TICK && active_ff) begin
         tick_in = (tick_ff != 16'd0) ? tick_ff - 16'd1 : 16'd0;
         if (phase_ff != PH_PACKET && phase_ff != PH_BETWEEN && tick_in == 16'd0) begin
            retries_in = retries_dec;
            has_job    = 1'b1;
            if (retries_dec == 8'd0) begin
               active_in = 1'b0;
               phase_in  = PH_WAIT;
               job.kind  = JOB_TIMEOUT;
            end else begin
               tick_in  = cfg.timeout_ticks;
               job.kind = JOB_SEND_C;
            end
         end
      end else if (command == CMD_BYTE && active_ff) begin
         unique case (phase_ff)
            PH_PACKET: begin
               if (is_data) begin
                  has_job           = 1'b1;
                  job.kind          = JOB_DATA;
                  job.data_byte     = rx_byte;
                  job.page_offset   = fill_ff[7:0];
                  job.flash_address = addr_ff;
                  fill_in           = fill_ff + PAGE_FILL_W'(1);
               end
               pkt_rem_in = rem_dec;
               if (rem_dec == '0) begin
                  // The closing byte never carries data, so the fill is unchanged here.
                  has_job           = 1'b1;
                  phase_in          = PH_BETWEEN;
                  job.flash_address = addr_ff;
                  if (fill_ff >= PAGE_FILL_W'(PAGE_BYTES)) begin
                     job.kind = (addr_ff[15:0] == 16'd0) ? JOB_ACK_ERASE_PROG : JOB_ACK_PROG;
                     addr_in  = addr_ff + ADDR_W'(PAGE_BYTES);
                     fill_in  = '0;
                  end else begin
                     job.kind = JOB_ACK;
                  end
               end
            end
            PH_BETWEEN: begin
               unique case (rx_byte)
                  CH_SOH: begin
                     phase_in   = PH_PACKET;
                     pkt_rem_in = PKT_REM_W'(PACKET_BYTES);
                  end
                  CH_EOT: begin
                     has_job  = 1'b1;
                     job.kind = JOB_ACK;
                  end
                  CH_ETB: begin
                     has_job   = 1'b1;
                     job.kind  = JOB_ACK_DONE;
                     active_in = 1'b0;
                     phase_in  = PH_WAIT;
                  end
                  CH_CAN: begin
                     has_job   = 1'b1;
                     job.kind  = JOB_CANCEL;
                     active_in = 1'b0;
                     phase_in  = PH_WAIT;
                  end
                  default: ;
               endcase
            end
            default: begin
               // Waiting for the first packet; an unused phase code behaves the same.
               if (rx_byte == CH_SOH) begin
                  phase_in   = PH_PACKET;
                  pkt_rem_in = PKT_REM_W'(PACKET_BYTES);
                  fill_in    = '0;
               end
            end
         endcase
      end
   end

   assign job_push = accept && has_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         phase_ff   <= PH_WAIT;
         pkt_rem_ff <= '0;
         fill_ff    <= '0;
         addr_ff    <= '0;
         tick_ff    <= '0;
         retries_ff <= '0;
      end else if (accept) begin
         active_ff  <= active_in;
         phase_ff   <= phase_in;
         pkt_rem_ff <= pkt_rem_in;
         fill_ff    <= fill_in;
         addr_ff    <= addr_in;
         tick_ff    <= tick_in;
         retries_ff <= retries_in;
      end
   end

endmodule

FILE: hdl/xrfw_queue.sv
// Small job queue between the front end and the back end.
module xrfw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xrfw_pkg::job_type  push_job,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output xrfw_pkg::job_type  head_job
);
   import xrfw_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hdl/xrfw_back.sv
// Back end: expands each job into its response beats through an output register.
module xrfw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_not_empty,
   input  xrfw_pkg::job_type            q_head,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,
   output logic [2:0]                   rsp_tuser,
   output logic                         rsp_tlast
);
   import xrfw_pkg::*;

   job_type           job_ff,       job_in;
   logic              job_valid_ff, job_valid_in;
   logic [1:0]        beat_ff,      beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        act_ff,       act_in;
   logic [7:0]        data_ff,      data_in;
   logic [7:0]        off_ff,       off_in;
   logic [ADDR_W-1:0] addr_ff,      addr_in;
   logic              last_ff,      last_in;

   logic              load;
   logic              final_beat;

   assign load = !rsp_valid_ff || rsp_tready;

   // Select the beat that the current job produces at the current position.
   always_comb begin
      act_in     = ACT_SEND;
      data_in    = 8'd0;
      off_in     = 8'd0;
      addr_in    = '0;
      final_beat = 1'b1;
      unique case (job_ff.kind)
         JOB_SEND_C: begin
            data_in = CH_START;
         end
         JOB_TIMEOUT: begin
            act_in = ACT_TIMEOUT;
         end
         JOB_DATA: begin
            act_in  = ACT_DATA;
            data_in = job_ff.data_byte;
            off_in  = job_ff.page_offset;
            addr_in = job_ff.flash_address;
         end
         JOB_ACK: begin
            data_in = CH_ACK;
         end
         JOB_ACK_PROG: begin
            if (beat_ff == 2'd0) begin
               data_in    = CH_ACK;
               final_beat = 1'b0;
            end else begin
               act_in  = ACT_PROGRAM;
               addr_in = job_ff.flash_address;
            end
         end
         JOB_ACK_ERASE_PROG: begin
            if (beat_ff == 2'd0) begin
               data_in    = CH_ACK;
               final_beat = 1'b0;
            end else if (beat_ff == 2'd1) begin
               act_in     = ACT_ERASE;
               addr_in    = job_ff.flash_address;
               final_beat = 1'b0;
            end else begin
               act_in  = ACT_PROGRAM;
               addr_in = job_ff.flash_address;
            end
         end
         JOB_ACK_DONE: begin
            if (beat_ff == 2'd0) begin
               data_in    = CH_ACK;
               final_beat = 1'b0;
            end else begin
               act_in = ACT_DONE;
            end
         end
         JOB_CANCEL: begin
            if (beat_ff == 2'd2) begin
               act_in = ACT_CANCEL;
            end else begin
               data_in    = CH_ACK;
               final_beat = 1'b0;
            end
         end
         default: ;
      endcase
      last_in = final_beat;
   end

   assign q_pop = q_not_empty && (!job_valid_ff || (load && final_beat));

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      beat_in      = beat_ff;
      if (q_pop) begin
         job_in       = q_head;
         job_valid_in = 1'b1;
         beat_in      = 2'd0;
      end else if (load && job_valid_ff) begin
         if (final_beat) begin
            job_valid_in = 1'b0;
         end
         beat_in = beat_ff + 2'd1;
      end
      rsp_valid_in = load ? job_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (load && job_valid_ff) begin
         act_ff  <= act_in;
         data_ff <= data_in;
         off_ff  <= off_in;
         addr_ff <= addr_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {addr_ff, off_ff, data_ff};
   assign rsp_tuser  = act_ff;
   assign rsp_tlast  = last_ff;

endmodule
